### rtl/gac_pkg.sv
// Package of constants shared by the gravity component datapath.
package gac_pkg;

  localparam int RES_BITS  = 4;
  localparam int FRAC_BITS = 16;

  // Exponent of two applied to x: the result is x * 2^K / s^1.5
  localparam int K_SHIFT   = FRAC_BITS + 6 + 2 * RES_BITS;

  localparam int IDX_W     = 8;
  localparam int SQ_W      = 2 * IDX_W;        // x^2 or y^2
  localparam int S_W       = SQ_W + 1;         // x^2 + y^2
  localparam int S2_W      = 2 * S_W;          // s^2
  localparam int D_W       = 3 * S_W;          // s^3
  localparam int Q_W       = 31;               // result width
  localparam int T_W       = SQ_W + 2 * K_SHIFT;

  // Working width of the remainder and trial terms
  localparam int TERM_W    = D_W + 2 * Q_W + 1;
  localparam int W_W       = ((T_W > TERM_W) ? T_W : TERM_W) + 1;

  localparam logic [Q_W-1:0] ACC_MAX = {Q_W{1'b1}};

endpackage

### rtl/gravity_accel_component.sv
// Top level: pipelined fixed-point inverse-square gravity x component.
//
//   channel   direction  signals                        meaning
//   --------  ---------  -----------------------------  ---------------------------
//   command   in         start, x_index, y_index        one grid point per transaction
//   command   out        busy                           held low, never refuses
//   result    out        done, accel, saturated         one-cycle strobe per transaction
//
// A transaction may enter in every cycle; it passes through four front stages
// (squares, sum, s^2, s^3), then the 31 restoring search stages, one result bit
// per stage, and finally the output register.
// Reset (rst, synchronous, active high) clears only the valid bits.
// The receiver cannot stall, so the pipeline never holds: it always advances.
module gravity_accel_component (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  x_index,
  input  logic [7:0]  y_index,
  output logic        busy,
  output logic        done,
  output logic [30:0] accel,
  output logic        saturated
);
  import gac_pkg::*;

  // Front stages: squares, sum, square of sum, cube of sum.
  logic             v0, v1, v2, v3;
  logic             z0, z1, z2, z3;
  logic [SQ_W-1:0]  xx0, yy0, xx1, xx2;
  logic [S_W-1:0]   s1, s2v;
  logic [S2_W-1:0]  ss2;
  logic [D_W-1:0]   d3;
  logic [W_W-1:0]   t3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= start;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
    xx0 <= SQ_W'(x_index) * SQ_W'(x_index);
    yy0 <= SQ_W'(y_index) * SQ_W'(y_index);
    z0  <= (x_index == '0);
    s1  <= S_W'(xx0) + S_W'(yy0);
    xx1 <= xx0;
    z1  <= z0;
    ss2 <= S2_W'(s1) * S2_W'(s1);
    s2v <= s1;
    xx2 <= xx1;
    z2  <= z1;
    d3  <= D_W'(ss2) * D_W'(s2v);
    t3  <= W_W'(xx2) << (2 * K_SHIFT);
    z3  <= z2;
  end

  // Search stages: stage j decides result bit Q_W-1-j.
  // r holds T - q^2*D, qd holds q*D.
  logic             sv  [1:Q_W];
  logic             sz  [1:Q_W];
  logic [W_W-1:0]   sr  [1:Q_W];
  logic [W_W-1:0]   sqd [1:Q_W];
  logic [W_W-1:0]   sd  [1:Q_W];
  logic [Q_W-1:0]   sq  [1:Q_W];

  logic [W_W-1:0]   in_r    [0:Q_W-1];
  logic [W_W-1:0]   in_qd   [0:Q_W-1];
  logic [W_W-1:0]   in_d    [0:Q_W-1];
  logic [Q_W-1:0]   in_q    [0:Q_W-1];

  logic [W_W-1:0]   r_next  [0:Q_W-1];
  logic [W_W-1:0]   qd_next [0:Q_W-1];
  logic [Q_W-1:0]   q_next  [0:Q_W-1];

  always_comb begin
    logic [W_W-1:0] term;
    in_r[0]  = t3;
    in_qd[0] = '0;
    in_d[0]  = W_W'(d3);
    in_q[0]  = '0;
    for (int j = 1; j < Q_W; j++) begin
      in_r[j]  = sr[j];
      in_qd[j] = sqd[j];
      in_d[j]  = sd[j];
      in_q[j]  = sq[j];
    end
    for (int j = 0; j < Q_W; j++) begin
      // Trial for bit i: (q + 2^i)^2 D - q^2 D = qD*2^(i+1) + D*2^(2i)
      term = (in_qd[j] << (Q_W - j)) + (in_d[j] << (2 * (Q_W - 1 - j)));
      if (term <= in_r[j]) begin
        r_next[j]  = in_r[j] - term;
        qd_next[j] = in_qd[j] + (in_d[j] << (Q_W - 1 - j));
        q_next[j]  = in_q[j] | (Q_W'(1) << (Q_W - 1 - j));
      end else begin
        r_next[j]  = in_r[j];
        qd_next[j] = in_qd[j];
        q_next[j]  = in_q[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[1] <= 1'b0;
    end else begin
      sv[1] <= v3;
    end
    sz[1] <= z3;
    for (int j = 1; j < Q_W; j++) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else begin
        sv[j+1] <= sv[j];
      end
      sz[j+1] <= sz[j];
    end
    for (int j = 0; j < Q_W; j++) begin
      sr[j+1]  <= r_next[j];
      sqd[j+1] <= qd_next[j];
      sd[j+1]  <= in_d[j];
      sq[j+1]  <= q_next[j];
    end
  end

  // Output register: force zero for a zero x index, flag the ceiling.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sv[Q_W];
    end
    accel     <= sz[Q_W] ? '0 : sq[Q_W];
    saturated <= !sz[Q_W] && (sq[Q_W] == ACC_MAX);
  end

  // Every cycle takes a transaction.
  assign busy = 1'b0;

endmodule

### test/gravity_accel_component_test.sv
// Self-checking testbench for the gravity_accel_component inverse-square x component.
`timescale 1ns / 100ps

module gravity_accel_component_test;
  import gac_pkg::*;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
  } grid_point_t;

  typedef struct packed {
    logic [30:0] accel;
    logic        sat;
  } gravity_t;

  localparam int CLK_HALF   = 4;
  localparam int RESET_CYC  = 11;
  localparam int LATENCY    = 36;
  localparam int CYCLE_CAP  = 200000;
  localparam int N_RANDOM   = 700;

  logic        clk;
  logic        rst;
  logic        start;
  logic [7:0]  x_index;
  logic [7:0]  y_index;
  logic        busy;
  logic        done;
  logic [30:0] accel;
  logic        saturated;

  grid_point_t points_pending[$];
  gravity_t    gravity_due[$];
  int          idle_pct;
  int          accepted;
  int          checked;
  int          n_sat;
  int          mismatches;
  int          cycles;

  gravity_accel_component i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .x_index   (x_index),
    .y_index   (y_index),
    .busy      (busy),
    .done      (done),
    .accel     (accel),
    .saturated (saturated)
  );

  // Largest q with q^2 * s^3 <= x^2 * 2^(2K), found one bit at a time from the top.
  function automatic gravity_t gravity_x(grid_point_t p);
    logic [127:0] s;
    logic [127:0] s_cubed;
    logic [127:0] bound;
    logic [127:0] trial;
    logic [30:0]  q;
    gravity_t     r;
    r = '0;
    if (p.x == 0) return r;
    s       = 128'(p.x) * p.x + 128'(p.y) * p.y;
    s_cubed = s * s * s;
    bound   = (128'(p.x) * p.x) << (2 * K_SHIFT);
    q = '0;
    for (int b = 30; b >= 0; b--) begin
      trial = 128'(q | (31'd1 << b));
      if (trial * trial * s_cubed <= bound) q[b] = 1'b1;
    end
    r.accel = q;
    // the search tops out at all ones only when the exact value reaches the maximum
    r.sat   = (q == ACC_MAX);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Cycle counter: end the run if the pipeline never drains.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, gravity_due.size());
      $display("gravity_accel_component verification failed");
      $finish;
    end
  end

  // Driver: present the head of the pending queue at the falling edge, idling at random.
  always @(negedge clk) begin
    if (!rst && points_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start   <= 1'b1;
      x_index <= points_pending[0].x;
      y_index <= points_pending[0].y;
    end else begin
      start   <= 1'b0;
      x_index <= 8'($urandom);
      y_index <= 8'($urandom);
    end
  end

  // Monitor: record each accepted transaction and check each result strobe.
  always @(posedge clk) begin
    gravity_t want;
    if (!rst && start && !busy) begin
      gravity_due.push_back(gravity_x('{x: x_index, y: y_index}));
      void'(points_pending.pop_front());
      accepted <= accepted + 1;
    end
    if (!rst && done) begin
      if (gravity_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result: accel=%0d saturated=%0b", accel, saturated);
      end else begin
        want = gravity_due.pop_front();
        checked <= checked + 1;
        if (want.sat) n_sat <= n_sat + 1;
        if (accel !== want.accel || saturated !== want.sat) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: accel exp %0d got %0d, saturated exp %0b got %0b",
                     want.accel, accel, want.sat, saturated);
        end
      end
    end
  end

  initial begin
    grid_point_t p;
    rst        = 1'b1;
    start      = 1'b0;
    x_index    = '0;
    y_index    = '0;
    idle_pct   = 0;
    accepted   = 0;
    checked    = 0;
    n_sat      = 0;
    mismatches = 0;
    cycles     = 0;
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed corners: zero x, points near the origin, the far corner and the axes.
    points_pending.push_back('{x: 8'd0,   y: 8'd0});
    points_pending.push_back('{x: 8'd0,   y: 8'd255});
    points_pending.push_back('{x: 8'd1,   y: 8'd0});
    points_pending.push_back('{x: 8'd1,   y: 8'd1});
    points_pending.push_back('{x: 8'd2,   y: 8'd3});
    points_pending.push_back('{x: 8'd255, y: 8'd255});
    points_pending.push_back('{x: 8'd255, y: 8'd0});
    points_pending.push_back('{x: 8'd1,   y: 8'd255});
    points_pending.push_back('{x: 8'd255, y: 8'd1});
    points_pending.push_back('{x: 8'd128, y: 8'd128});
    points_pending.push_back('{x: 8'd170, y: 8'd85});
    points_pending.push_back('{x: 8'd85,  y: 8'd170});
    points_pending.push_back('{x: 8'd16,  y: 8'd0});
    points_pending.push_back('{x: 8'd8,   y: 8'd8});
    points_pending.push_back('{x: 8'd32,  y: 8'd200});
    wait (points_pending.size() == 0);

    // Random points in phases of sender idling; a third keep small indices
    // so that points near the origin are exercised often.
    for (int i = 0; i < N_RANDOM; i++) begin
      case (i / 175)
        0:       idle_pct = 0;
        1:       idle_pct = 70;
        2:       idle_pct = 29;
        default: idle_pct = $urandom_range(1) ? 0 : 70;
      endcase
      if ($urandom_range(2) == 0) begin
        p.x = 8'($urandom_range(12));
        p.y = 8'($urandom_range(12));
      end else begin
        p.x = 8'($urandom);
        p.y = 8'($urandom);
      end
      points_pending.push_back(p);
      wait (points_pending.size() < 4);
    end
    wait (points_pending.size() == 0);
    wait (gravity_due.size() == 0);
    repeat (LATENCY + 8) @(posedge clk);

    $display("%0d grid points driven, %0d results checked, %0d saturated, %0d mismatches",
             accepted, checked, n_sat, mismatches);
    $display("idle phases covered: none, 70 and 29 in a hundred, and a mixed tail");
    if (mismatches == 0 && gravity_due.size() == 0) begin
      $display("gravity_accel_component verification clean");
    end else begin
      $display("gravity_accel_component verification failed");
    end
    $finish;
  end

endmodule
